// ===== src/fed_pkg.sv =====
package fed_pkg;

    // Sample and store geometry
    localparam int SAMPLE_BITS = 24;
    localparam int STORE_DEPTH = 131072;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int IO_W        = 2 * SAMPLE_BITS;

    // Configuration register widths
    localparam int DELAY_W    = 17;
    localparam int FRAC_W     = 16;
    localparam int GAIN_W     = 16;
    localparam int MIX_W      = 17;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 17;

    // Shared multiply-round-add unit
    localparam int FRAC_BITS = 16;
    localparam int DIFF_W    = SAMPLE_BITS + 1;
    localparam int COEF_W    = 17;
    localparam int PROD_W    = DIFF_W + COEF_W + 1;

    // Register indexes on the configuration port
    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_DELAY_WHOLE    = 2'd0,
        CFG_DELAY_FRACTION = 2'd1,
        CFG_FEEDBACK_GAIN  = 2'd2,
        CFG_WET_MIX        = 2'd3
    } cfg_index_t;

    // Register reset values and limits
    localparam logic [DELAY_W-1:0] DELAY_WHOLE_RST    = 17'd24000;
    localparam logic [FRAC_W-1:0]  DELAY_FRACTION_RST = 16'd0;
    localparam logic [GAIN_W-1:0]  FEEDBACK_GAIN_RST  = 16'd32768;
    localparam logic [MIX_W-1:0]   WET_MIX_RST        = 17'd19661;
    localparam logic [GAIN_W-1:0]  FEEDBACK_CAP       = 16'd62259;
    localparam logic [MIX_W-1:0]   WET_FULL           = 17'd65536;

    // One operation for the shared unit: addend + round(opa * coef / 2^16), saturated.
    typedef struct packed {
        logic                          en;
        logic signed [DIFF_W-1:0]      opa;
        logic [COEF_W-1:0]             coef;
        logic signed [SAMPLE_BITS-1:0] addend;
    } mac_req_t;

endpackage

// ===== src/fed_mac.sv =====
// Two-stage multiply, round half up, add and saturate. One operation may enter every cycle;
// its product is registered first, then its saturated sum. Both stages hold while en is low.
module fed_mac (
    input  logic                                  aclk,
    input  fed_pkg::mac_req_t                     req,
    output logic signed [fed_pkg::SAMPLE_BITS-1:0] result
);

    localparam int SUM_W = fed_pkg::PROD_W - fed_pkg::FRAC_BITS + 1;
    localparam logic signed [SUM_W-1:0] SAT_HI =
        SUM_W'({1'b0, {(fed_pkg::SAMPLE_BITS-1){1'b1}}});
    localparam logic signed [SUM_W-1:0] SAT_LO = ~SAT_HI;

    logic signed [fed_pkg::PROD_W-1:0]      prod_reg;
    logic signed [fed_pkg::PROD_W-1:0]      prod_next;
    logic signed [fed_pkg::SAMPLE_BITS-1:0] addend_reg;
    logic signed [fed_pkg::SAMPLE_BITS-1:0] res_reg;
    logic signed [fed_pkg::SAMPLE_BITS-1:0] res_next;
    logic signed [fed_pkg::PROD_W-1:0]      biased;
    logic signed [fed_pkg::PROD_W-1:0]      shifted;
    logic signed [SUM_W-1:0]                sum;

    always_comb begin
        prod_next = fed_pkg::PROD_W'(req.opa) *
                    fed_pkg::PROD_W'($signed({1'b0, req.coef}));
    end

    // Floor of (p + 2^15) / 2^16 is round half toward plus infinity.
    always_comb begin
        biased  = prod_reg + (fed_pkg::PROD_W'(1) << (fed_pkg::FRAC_BITS - 1));
        shifted = biased >>> fed_pkg::FRAC_BITS;
        sum     = SUM_W'(shifted) + SUM_W'(addend_reg);
        if (sum > SAT_HI) begin
            res_next = SAT_HI[fed_pkg::SAMPLE_BITS-1:0];
        end else if (sum < SAT_LO) begin
            res_next = SAT_LO[fed_pkg::SAMPLE_BITS-1:0];
        end else begin
            res_next = sum[fed_pkg::SAMPLE_BITS-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (req.en) begin
            prod_reg   <= prod_next;
            addend_reg <= req.addend;
            res_reg    <= res_next;
        end
    end

    assign result = res_reg;

endmodule

// ===== src/feedback_echo_delay.sv =====
// Stereo feedback echo with a fractional delay.
//
// Input transactions arrive on the s_ stream: s_tdata carries left_in in bits [23:0] and
// right_in in bits [47:24], both signed Q1.23. Each output transaction on the m_ stream
// carries left_out and right_out in the same layout. The four registers (whole delay,
// fractional delay, feedback gain, wet share) are written through cfg_we/cfg_addr/cfg_wdata;
// the user must write them only while the block is idle, and the block does not enforce it.
//
// Each sample pair is handled by one shared multiply-round-add unit that performs six
// operations in turn (interpolation, feedback and mix for each channel), after two reads of
// the delay memory that holds both channels side by side. An accepted transaction passes
// through the read, operation, write and done steps before it shows up on m_tvalid, and
// s_tready rises in that same cycle, so the block takes no new sample pair until the last
// one is finished. The single memory read port and the shared unit set this pace.
//
// Reset (synchronous, active low on aresetn) returns the registers to their defaults and
// the write pointer to zero. The memory is not swept: the write pointer and a wrap flag
// tell which entries have been written, and any other entry reads as zero, so the block
// is ready in the first cycle after reset.
//
// The result waits in an output register. A new pair may be accepted while it waits; if
// the receiver still stalls when the next result is ready, the sequencer holds until the
// output register is free.
module feedback_echo_delay (
    input  logic                             aclk,
    input  logic                             aresetn,

    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [fed_pkg::IO_W-1:0]         s_tdata,   // left_in [23:0], right_in [47:24]

    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [fed_pkg::IO_W-1:0]         m_tdata,   // left_out [23:0], right_out [47:24]

    input  logic                             cfg_we,
    input  logic [fed_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [fed_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    localparam int SB = fed_pkg::SAMPLE_BITS;

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    // Steps of the sequencer within one sample pair.
    typedef enum logic [3:0] {
        STEP_RD_A  = 4'd0,
        STEP_RD_B  = 4'd1,
        STEP_L_DLY = 4'd2,
        STEP_R_DLY = 4'd3,
        STEP_L_FB  = 4'd4,
        STEP_R_FB  = 4'd5,
        STEP_L_MIX = 4'd6,
        STEP_R_MIX = 4'd7,
        STEP_WRITE = 4'd8,
        STEP_DONE  = 4'd9
    } step_t;

    // Configuration registers
    logic [fed_pkg::DELAY_W-1:0] delay_whole_reg;
    logic [fed_pkg::FRAC_W-1:0]  delay_fraction_reg;
    logic [fed_pkg::GAIN_W-1:0]  feedback_gain_reg;
    logic [fed_pkg::MIX_W-1:0]   wet_mix_reg;

    // Sequencer control
    state_t                      state_reg, state_next;
    step_t                       step_reg, step_next;
    logic [fed_pkg::ADDR_W-1:0]  wp_reg, wp_next;
    logic                        wrap_reg, wrap_next;
    logic                        m_tvalid_reg, m_tvalid_next;
    logic [fed_pkg::IO_W-1:0]    m_tdata_reg, m_tdata_next;

    // Per-item working values
    logic signed [SB-1:0]        in_l_reg, in_r_reg;
    logic [fed_pkg::ADDR_W-1:0]  ia_reg, ib_reg;
    logic                        va_reg, vb_reg;
    logic signed [SB-1:0]        a_l_reg, a_r_reg;
    logic signed [SB-1:0]        dly_l_reg, dly_r_reg;
    logic signed [SB-1:0]        fb_l_reg, fb_r_reg;
    logic signed [SB-1:0]        out_l_reg;

    // Delay memory: right channel in the upper half of each word.
    logic [2*SB-1:0]             store_mem [fed_pkg::STORE_DEPTH];
    logic [2*SB-1:0]             mem_q_reg;
    logic                        mem_re, mem_we;
    logic [fed_pkg::ADDR_W-1:0]  mem_raddr;

    // Clamped settings and tap addresses
    logic [fed_pkg::ADDR_W-1:0]  whole_c;
    logic [fed_pkg::GAIN_W-1:0]  gain_c;
    logic [fed_pkg::MIX_W-1:0]   mix_c;
    logic [fed_pkg::ADDR_W-1:0]  ia_next, ib_next;

    logic                        s_accept;
    logic                        run;
    logic                        adv;
    logic signed [SB-1:0]        b_l, b_r;
    fed_pkg::mac_req_t           mac_req;
    logic signed [SB-1:0]        mac_res;

    assign s_accept = s_tvalid && s_tready;
    assign run      = (state_reg == ST_RUN);
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // The last step waits while the output register still holds an untaken result.
    assign adv = !((step_reg == STEP_DONE) && m_tvalid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            delay_whole_reg    <= fed_pkg::DELAY_WHOLE_RST;
            delay_fraction_reg <= fed_pkg::DELAY_FRACTION_RST;
            feedback_gain_reg  <= fed_pkg::FEEDBACK_GAIN_RST;
            wet_mix_reg        <= fed_pkg::WET_MIX_RST;
        end else if (cfg_we) begin
            case (fed_pkg::cfg_index_t'(cfg_addr))
                fed_pkg::CFG_DELAY_WHOLE: begin
                    delay_whole_reg <= cfg_wdata[fed_pkg::DELAY_W-1:0];
                end
                fed_pkg::CFG_DELAY_FRACTION: begin
                    delay_fraction_reg <= cfg_wdata[fed_pkg::FRAC_W-1:0];
                end
                fed_pkg::CFG_FEEDBACK_GAIN: begin
                    feedback_gain_reg <= cfg_wdata[fed_pkg::GAIN_W-1:0];
                end
                fed_pkg::CFG_WET_MIX: begin
                    wet_mix_reg <= cfg_wdata[fed_pkg::MIX_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // A whole delay of zero acts as one; one beyond the store depth less two is held at that
    // bound, which keeps both taps off the slot being written. Gain and wet share are capped.
    always_comb begin
        if (delay_whole_reg == '0) begin
            whole_c = fed_pkg::ADDR_W'(1);
        end else if (32'(delay_whole_reg) > 32'(fed_pkg::STORE_DEPTH - 2)) begin
            whole_c = fed_pkg::ADDR_W'(fed_pkg::STORE_DEPTH - 2);
        end else begin
            whole_c = fed_pkg::ADDR_W'(delay_whole_reg);
        end
        gain_c  = (feedback_gain_reg > fed_pkg::FEEDBACK_CAP) ? fed_pkg::FEEDBACK_CAP
                                                             : feedback_gain_reg;
        mix_c   = (wet_mix_reg > fed_pkg::WET_FULL) ? fed_pkg::WET_FULL : wet_mix_reg;
        ia_next = wp_reg - whole_c;
        ib_next = ia_next - fed_pkg::ADDR_W'(1);
    end

    // Memory: reads of both taps in the first two steps, write of the feedback word later.
    assign mem_re    = run && ((step_reg == STEP_RD_A) || (step_reg == STEP_RD_B));
    assign mem_we    = run && (step_reg == STEP_WRITE);
    assign mem_raddr = (step_reg == STEP_RD_A) ? ia_reg : ib_reg;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            store_mem[wp_reg] <= {fb_r_reg, fb_l_reg};
        end
        if (mem_re) begin
            mem_q_reg <= store_mem[mem_raddr];
        end
    end

    // The older tap is in the read register from the third step on.
    assign b_l = vb_reg ? $signed(mem_q_reg[SB-1:0])    : '0;
    assign b_r = vb_reg ? $signed(mem_q_reg[2*SB-1:SB]) : '0;

    always_comb begin
        mac_req        = '0;
        mac_req.en     = run && adv;
        case (step_reg)
            STEP_L_DLY: begin
                mac_req.opa    = fed_pkg::DIFF_W'(b_l) - fed_pkg::DIFF_W'(a_l_reg);
                mac_req.coef   = fed_pkg::COEF_W'(delay_fraction_reg);
                mac_req.addend = a_l_reg;
            end
            STEP_R_DLY: begin
                mac_req.opa    = fed_pkg::DIFF_W'(b_r) - fed_pkg::DIFF_W'(a_r_reg);
                mac_req.coef   = fed_pkg::COEF_W'(delay_fraction_reg);
                mac_req.addend = a_r_reg;
            end
            STEP_L_FB: begin
                mac_req.opa    = fed_pkg::DIFF_W'(mac_res);
                mac_req.coef   = fed_pkg::COEF_W'(gain_c);
                mac_req.addend = in_l_reg;
            end
            STEP_R_FB: begin
                mac_req.opa    = fed_pkg::DIFF_W'(mac_res);
                mac_req.coef   = fed_pkg::COEF_W'(gain_c);
                mac_req.addend = in_r_reg;
            end
            STEP_L_MIX: begin
                mac_req.opa    = fed_pkg::DIFF_W'(dly_l_reg) - fed_pkg::DIFF_W'(in_l_reg);
                mac_req.coef   = mix_c;
                mac_req.addend = in_l_reg;
            end
            STEP_R_MIX: begin
                mac_req.opa    = fed_pkg::DIFF_W'(dly_r_reg) - fed_pkg::DIFF_W'(in_r_reg);
                mac_req.coef   = mix_c;
                mac_req.addend = in_r_reg;
            end
            default: begin
            end
        endcase
    end

    fed_mac u_mac (
        .aclk   (aclk),
        .req    (mac_req),
        .result (mac_res)
    );

    // Working values. Each result of the shared unit is captured once it has passed both stages.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_l_reg <= $signed(s_tdata[SB-1:0]);
            in_r_reg <= $signed(s_tdata[2*SB-1:SB]);
            ia_reg   <= ia_next;
            ib_reg   <= ib_next;
            va_reg   <= wrap_reg || (ia_next < wp_reg);
            vb_reg   <= wrap_reg || (ib_next < wp_reg);
        end
        if (run) begin
            case (step_reg)
                STEP_RD_B: begin
                    a_l_reg <= va_reg ? $signed(mem_q_reg[SB-1:0])    : '0;
                    a_r_reg <= va_reg ? $signed(mem_q_reg[2*SB-1:SB]) : '0;
                end
                STEP_L_FB:  dly_l_reg <= mac_res;
                STEP_R_FB:  dly_r_reg <= mac_res;
                STEP_L_MIX: fb_l_reg  <= mac_res;
                STEP_R_MIX: fb_r_reg  <= mac_res;
                STEP_WRITE: out_l_reg <= mac_res;
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        state_next    = state_reg;
        step_next     = step_reg;
        wp_next       = wp_reg;
        wrap_next     = wrap_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_RUN;
                    step_next  = STEP_RD_A;
                end
            end
            ST_RUN: begin
                if (adv) begin
                    if (step_reg == STEP_DONE) begin
                        state_next    = ST_IDLE;
                        m_tvalid_next = 1'b1;
                        m_tdata_next  = fed_pkg::IO_W'({mac_res, out_l_reg});
                        wp_next       = wp_reg + fed_pkg::ADDR_W'(1);
                        if (wp_reg == '1) begin
                            wrap_next = 1'b1;
                        end
                    end else begin
                        step_next = step_t'(step_reg + 4'd1);
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            step_reg     <= STEP_RD_A;
            wp_reg       <= '0;
            wrap_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            step_reg     <= step_next;
            wp_reg       <= wp_next;
            wrap_reg     <= wrap_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        m_tdata_reg <= m_tdata_next;
    end

endmodule

// ===== src/fed_checker.sv =====
module fed_checker (
    input logic                     aclk,
    input logic                     aresetn,
    input logic                     s_tvalid,
    input logic                     s_tready,
    input logic                     m_tvalid,
    input logic                     m_tready,
    input logic [fed_pkg::IO_W-1:0] m_tdata
);

    // One sample pair at a time: after a transaction the input side closes.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted again right after a transaction");

    // The input side is still closed at the last of the ten working steps.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |-> ##10 !s_tready)
        else $error("input reopened before the pair was finished");

    // Finishing a pair always leaves its result waiting on the output.
    assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && $rose(s_tready)) |-> m_tvalid)
        else $error("pair finished without a result on the output");

    // A stalled result holds its value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled output transaction changed or vanished");

endmodule

bind feedback_echo_delay fed_checker u_fed_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

// Self-checking bench for the stereo feedback echo.
//
// A clocked driver feeds sample pairs from a queue onto the s_ stream. A clocked
// monitor predicts each accepted pair with its own copy of the two delay memories
// and checks every transaction on the m_ stream against the oldest prediction.
// The stimulus runs in phases. Each phase starts from an idle block with new
// register settings, and its samples come from a mix of random, small, silent and
// full-scale values, so that echoes build up, decay and saturate.
module tb;
    import fed_pkg::*;

    localparam int     CYCLE_LIMIT  = 500_000;
    localparam int     RANDOM_PAIRS = 850;
    localparam longint SAMPLE_HI    = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
    localparam longint SAMPLE_LO    = -SAMPLE_HI - 1;
    localparam longint UNITY        = 65536;

    // The left channel sits in the low half, which matches the port layout.
    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] right;
        logic signed [SAMPLE_BITS-1:0] left;
    } stereo_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    stereo_t               s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [IO_W-1:0]       m_tdata;
    logic                  cfg_we    = 1'b0;
    cfg_index_t            cfg_addr  = CFG_DELAY_WHOLE;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    feedback_echo_delay u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Sample pairs waiting to be driven, and mixed pairs waiting to come out.
    stereo_t pending_pairs[$];
    stereo_t expected_mix[$];
    stereo_t expected_head;
    stereo_t observed_pair;

    // The bench's own copy of the block state: two delay memories, the write
    // pointer, and the four registers as last written.
    logic signed [SAMPLE_BITS-1:0] echo_mem [0:1][0:STORE_DEPTH-1];
    int unsigned echo_wp;
    int unsigned reg_delay;
    int unsigned reg_frac;
    int unsigned reg_gain;
    int unsigned reg_wet;

    int  cycle_count    = 0;
    int  pairs_queued   = 0;
    int  pairs_checked  = 0;
    int  mismatch_count = 0;
    int  settings_used  = 0;
    int  send_gap       = 0;
    int  stall_left     = 0;
    bit  s_took         = 1'b0;
    // When set, neither side idles, which gives stretches at the full block rate.
    bit  calm           = 1'b0;

    task automatic report_mismatch(string what);
        mismatch_count++;
        if (mismatch_count <= 40)
            $display("[%0t] result %0d: %s", $time, pairs_checked, what);
    endtask

    // Product scaled back by 2^16 with round half up; >>> floors on a signed value.
    function automatic longint round_q16(longint v);
        return (v + 32768) >>> 16;
    endfunction

    function automatic longint clamp_sample(longint v);
        if (v > SAMPLE_HI) return SAMPLE_HI;
        if (v < SAMPLE_LO) return SAMPLE_LO;
        return v;
    endfunction

    // One channel of one pair. The interpolation blends the tap lag samples back
    // with the one just older than it, by the fractional delay. The memory then
    // takes the dry input plus the scaled echo, saturated, at the write pointer.
    function automatic logic signed [SAMPLE_BITS-1:0] echo_channel(
        int ch, logic signed [SAMPLE_BITS-1:0] dry,
        longint lag, longint frac, longint gain, longint wet);
        longint      dry_v;
        longint      tap_near;
        longint      tap_far;
        longint      delayed;
        longint      fed_back;
        longint      mixed;
        int unsigned near_idx;
        int unsigned far_idx;
        dry_v    = dry;
        near_idx = (echo_wp + STORE_DEPTH - lag) % STORE_DEPTH;
        far_idx  = (echo_wp + STORE_DEPTH - lag - 1) % STORE_DEPTH;
        tap_near = echo_mem[ch][near_idx];
        tap_far  = echo_mem[ch][far_idx];
        delayed  = round_q16(tap_near * (UNITY - frac) + tap_far * frac);
        fed_back = clamp_sample(dry_v + round_q16(delayed * gain));
        echo_mem[ch][echo_wp] = fed_back[SAMPLE_BITS-1:0];
        mixed    = clamp_sample(round_q16(dry_v * (UNITY - wet) + delayed * wet));
        return mixed[SAMPLE_BITS-1:0];
    endfunction

    // Applies the register limits, runs both channels and advances the pointer.
    // A zero delay acts as one sample; a delay beyond the memory depth less two
    // acts as that bound, so neither tap hits the entry being written.
    function automatic stereo_t echo_predict(stereo_t dry);
        longint  lag;
        longint  gain;
        longint  wet;
        stereo_t mixed_pair;
        lag = reg_delay;
        if (lag < 1) lag = 1;
        if (lag > STORE_DEPTH - 2) lag = STORE_DEPTH - 2;
        gain = (reg_gain > FEEDBACK_CAP) ? FEEDBACK_CAP : reg_gain;
        wet  = (reg_wet > WET_FULL) ? WET_FULL : reg_wet;
        mixed_pair.left  = echo_channel(0, dry.left, lag, reg_frac, gain, wet);
        mixed_pair.right = echo_channel(1, dry.right, lag, reg_frac, gain, wet);
        echo_wp = (echo_wp + 1) % STORE_DEPTH;
        return mixed_pair;
    endfunction

    // Monitor: tracks register writes, predicts every accepted pair and checks
    // every result. All of it samples at the rising edge.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d of %0d results checked.",
                     CYCLE_LIMIT, pairs_checked, pairs_queued);
            $display("feedback_echo_delay: mismatch");
            $finish;
        end else if (!aresetn) begin
            reg_delay = DELAY_WHOLE_RST;
            reg_frac  = DELAY_FRACTION_RST;
            reg_gain  = FEEDBACK_GAIN_RST;
            reg_wet   = WET_MIX_RST;
            echo_wp   = 0;
        end else begin
            // Fraction and gain registers keep only their low 16 bits.
            if (cfg_we) begin
                case (cfg_addr)
                    CFG_DELAY_WHOLE:    reg_delay = cfg_wdata;
                    CFG_DELAY_FRACTION: reg_frac  = cfg_wdata[FRAC_W-1:0];
                    CFG_FEEDBACK_GAIN:  reg_gain  = cfg_wdata[GAIN_W-1:0];
                    CFG_WET_MIX:        reg_wet   = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                expected_mix.push_back(echo_predict(s_tdata));
                s_took = 1'b1;
            end
            if (m_tvalid && m_tready) begin
                observed_pair = m_tdata;
                if (expected_mix.size() == 0) begin
                    report_mismatch($sformatf("unexpected result left %0d right %0d",
                                              observed_pair.left, observed_pair.right));
                end else begin
                    expected_head = expected_mix.pop_front();
                    pairs_checked++;
                    if (observed_pair.left !== expected_head.left)
                        report_mismatch($sformatf("left_out %0d, expected %0d",
                                                  observed_pair.left, expected_head.left));
                    if (observed_pair.right !== expected_head.right)
                        report_mismatch($sformatf("right_out %0d, expected %0d",
                                                  observed_pair.right, expected_head.right));
                end
            end
        end
    end

    // Idle lengths for both sides: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) return 0;
        if (roll < 85) return $urandom_range(1, 3);
        if (roll < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Driver: holds a pair until its transaction completes, then waits out the
    // gap drawn for it before presenting the next one.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (s_tvalid && !s_took) begin
            // The current pair has not been taken yet.
        end else begin
            s_took = 1'b0;
            if (send_gap > 0) begin
                send_gap--;
                s_tvalid <= 1'b0;
            end else if (pending_pairs.size() > 0) begin
                s_tdata  <= pending_pairs.pop_front();
                s_tvalid <= 1'b1;
                send_gap = calm ? 0 : pick_gap();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: ready by default, with stalls of random length in between.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            if (!calm) stall_left = pick_gap();
        end
    end

    function automatic void queue_pair(longint l, longint r);
        stereo_t p;
        p.left  = l[SAMPLE_BITS-1:0];
        p.right = r[SAMPLE_BITS-1:0];
        pending_pairs.push_back(p);
        pairs_queued++;
    endfunction

    // Random samples: plain noise, quiet signal, silence so that echo tails show
    // on their own, values at full scale to drive saturation, and mid levels.
    function automatic longint pick_sample();
        int                            roll;
        logic signed [SAMPLE_BITS-1:0] raw;
        roll = $urandom_range(0, 99);
        raw  = SAMPLE_BITS'($urandom);
        if (roll < 40) return raw;
        if (roll < 60) return int'($urandom_range(0, 4000)) - 2000;
        if (roll < 75) return 0;
        if (roll < 90) begin
            if ($urandom_range(0, 1) == 0) return SAMPLE_HI - $urandom_range(0, 3);
            return SAMPLE_LO + $urandom_range(0, 3);
        end
        return int'($urandom_range(0, 1 << 22)) - (1 << 21);
    endfunction

    // Mostly short delays so that echoes come back within a phase; a few reach
    // the clamp at both ends of the range.
    function automatic logic [CFG_DATA_W-1:0] pick_delay();
        int roll;
        roll = $urandom_range(0, 19);
        if (roll < 2)  return $urandom_range(0, 2);
        if (roll < 12) return $urandom_range(1, 40);
        if (roll < 16) return $urandom_range(41, 900);
        if (roll < 18) return $urandom_range(STORE_DEPTH - 4, STORE_DEPTH - 1);
        return $urandom_range(0, STORE_DEPTH - 1);
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_fraction();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0) return 0;
        if (roll == 1) return 65535;
        if (roll == 2) return 32768;
        return CFG_DATA_W'($urandom);
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_gain();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0) return 0;
        if (roll == 1) return FEEDBACK_CAP;
        if (roll == 2) return $urandom_range(FEEDBACK_CAP + 1, 65535);
        if (roll == 3) return CFG_DATA_W'($urandom);
        return $urandom_range(0, FEEDBACK_CAP);
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_wet();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll == 0) return 0;
        if (roll == 1) return WET_FULL;
        if (roll == 2) return $urandom_range(WET_FULL + 1, (1 << CFG_DATA_W) - 1);
        return $urandom_range(0, WET_FULL);
    endfunction

    task automatic write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] value);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_we    <= 1'b0;
    endtask

    // Holds the sender until every queued pair has come back checked, then lets
    // the pipeline run dry before the next register writes.
    task automatic settle();
        while (pairs_checked < pairs_queued) @(negedge aclk);
        repeat (12) @(negedge aclk);
    endtask

    initial begin
        int phase_pairs;
        int random_sent;
        random_sent = 0;
        for (int i = 0; i < STORE_DEPTH; i++) begin
            echo_mem[0][i] = '0;
            echo_mem[1][i] = '0;
        end
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Register defaults after reset. The delay reaches back into memory that
        // was never written, so the output is the dry signal scaled down.
        settings_used++;
        queue_pair(SAMPLE_HI, SAMPLE_LO);
        queue_pair(SAMPLE_LO, SAMPLE_HI);
        queue_pair(0, 0);
        queue_pair(-1, 1);
        queue_pair(1, -1);
        settle();

        // A zero delay acts as one sample, the gain above its cap is held at 0.95
        // and the wet share above one at fully wet. Repeated full-scale input
        // drives the feedback write into saturation.
        write_reg(CFG_DELAY_WHOLE, 0);
        write_reg(CFG_DELAY_FRACTION, 0);
        write_reg(CFG_FEEDBACK_GAIN, 65535);
        write_reg(CFG_WET_MIX, (1 << CFG_DATA_W) - 1);
        settings_used++;
        repeat (5) queue_pair(SAMPLE_HI, SAMPLE_LO);
        repeat (2) queue_pair(SAMPLE_LO, SAMPLE_HI);
        settle();

        // The largest delay is clamped to two short of the memory depth. The
        // fraction and gain writes carry a bit above their width, which is
        // dropped, so the gain becomes zero. A dry-only mix passes input through.
        write_reg(CFG_DELAY_WHOLE, (1 << CFG_DATA_W) - 1);
        write_reg(CFG_DELAY_FRACTION, (1 << CFG_DATA_W) - 1);
        write_reg(CFG_FEEDBACK_GAIN, 1 << GAIN_W);
        write_reg(CFG_WET_MIX, 0);
        settings_used++;
        queue_pair(SAMPLE_HI, SAMPLE_LO);
        queue_pair(0, 0);
        queue_pair(-1, -1);
        settle();

        // Short delay with a half-sample fraction at the exact gain cap: single
        // impulses followed by silence show the interpolated, decaying echo.
        write_reg(CFG_DELAY_WHOLE, 2);
        write_reg(CFG_DELAY_FRACTION, 32768);
        write_reg(CFG_FEEDBACK_GAIN, FEEDBACK_CAP);
        write_reg(CFG_WET_MIX, WET_FULL);
        settings_used++;
        queue_pair(SAMPLE_HI, SAMPLE_LO);
        repeat (3) queue_pair(0, 0);
        queue_pair(SAMPLE_LO, SAMPLE_HI);
        repeat (3) queue_pair(0, 0);
        settle();

        // Random phases. Each one starts idle (the sender has already waited for
        // every result) and rewrites some of the registers. The memories and the
        // write pointer carry over, so longer delays hear earlier phases.
        while (random_sent < RANDOM_PAIRS) begin
            calm = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 3) != 0) write_reg(CFG_DELAY_WHOLE, pick_delay());
            if ($urandom_range(0, 3) != 0) write_reg(CFG_DELAY_FRACTION, pick_fraction());
            if ($urandom_range(0, 3) != 0) write_reg(CFG_FEEDBACK_GAIN, pick_gain());
            if ($urandom_range(0, 3) != 0) write_reg(CFG_WET_MIX, pick_wet());
            settings_used++;
            phase_pairs = $urandom_range(20, 90);
            for (int k = 0; k < phase_pairs; k++) queue_pair(pick_sample(), pick_sample());
            random_sent += phase_pairs;
            settle();
        end

        $display("Ran %0d stereo pairs through %0d register settings, %0d results checked,",
                 pairs_queued, settings_used, pairs_checked);
        $display("covering delay, gain and mix clamps, feedback saturation and echo decay.");
        if (mismatch_count == 0) begin
            $display("feedback_echo_delay: match");
        end else begin
            $display("feedback_echo_delay: mismatch");
        end
        $finish;
    end

endmodule

// ===== files.f =====
src/fed_pkg.sv
src/fed_mac.sv
src/feedback_echo_delay.sv
src/fed_checker.sv
sim/tb.sv
